>>> rtl/energy_vad_hangover_macros.svh
// Assertion macros for the energy VAD with hangover.
`ifndef ENERGY_VAD_HANGOVER_MACROS_SVH
`define ENERGY_VAD_HANGOVER_MACROS_SVH
`ifndef ASSERT_OFF
`define EVH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EVH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EVH_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EVH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/evh_pkg.sv
// Shared types and constants for the energy VAD with hangover.
`timescale 1ns / 1ps
package evh_pkg;
    localparam int DEF_MAX_FRAME_LENGTH = 1024;
    localparam int DEF_SAMPLE_BITS      = 16;

    localparam int FL_W     = 11;
    localparam int THR_W    = 31;
    localparam int HANG_W   = 10;
    localparam int CNT_W    = 10;
    localparam int ENERGY_W = 41;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [CNT_W-1:0]    COUNT_MAX  = '1;

    localparam logic [FL_W-1:0]   RST_FRAME_LENGTH = 11'd400;
    localparam logic [THR_W-1:0]  RST_THRESHOLD    = 31'd1000000;
    localparam logic [HANG_W-1:0] RST_HANGOVER     = 10'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER     = 2'd2;

    localparam logic [1:0] VAD_SILENCE  = 2'd0;
    localparam logic [1:0] VAD_SPEECH   = 2'd1;
    localparam logic [1:0] VAD_HANGOVER = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [2:0] {
        ST_SILENCE  = 3'b001,
        ST_SPEECH   = 3'b010,
        ST_HANGOVER = 3'b100
    } t_mode;

    typedef struct packed {
        logic               not_empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        unique case (m)
            ST_SPEECH:   c = VAD_SPEECH;
            ST_HANGOVER: c = VAD_HANGOVER;
            default:     c = VAD_SILENCE;
        endcase
        return c;
    endfunction
endpackage

>>> rtl/evh_queue.sv
// Frame energy queue between the accumulating front and the decision back end.
`timescale 1ns / 1ps
module evh_queue
    import evh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [ENERGY_W-1:0] i_data,
    input  logic                i_pop,
    output logic [ENERGY_W-1:0] o_data,
    output t_q_stat             o_stat
);
    logic [ENERGY_W-1:0] r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wptr, r_rptr;
    logic [Q_CNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    assign o_data           = r_mem[r_rptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.count     = r_count;
endmodule

>>> rtl/evh_front.sv
// Front end: takes samples, squares them and sums each frame into the queue.
`timescale 1ns / 1ps
module evh_front
    import evh_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = DEF_MAX_FRAME_LENGTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS,
    localparam int POS_W = $clog2(MAX_FRAME_LENGTH),
    localparam int LEN_W = POS_W + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [LEN_W-1:0]       i_len,
    input  t_q_stat                i_q_stat,
    output logic                   o_push,
    output logic [ENERGY_W-1:0]    o_push_data
);
    localparam int SQ_W  = 2 * SAMPLE_BITS;
    localparam int SUM_W = ((SQ_W > ENERGY_W) ? SQ_W : ENERGY_W) + 1;

    logic [POS_W-1:0]    r_pos, n_pos;
    logic [SQ_W-1:0]     r_sq;
    logic                r_sq_vld;
    logic                r_sq_last;
    logic [ENERGY_W-1:0] r_acc;

    logic                   accept;
    logic [LEN_W-1:0]       pos_inc;
    logic                   last;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        sq;
    logic [SUM_W-1:0]       sum;
    logic [ENERGY_W-1:0]    acc_sat;

    // room for this request plus a frame end still in the square stage
    assign o_in_ready = ({1'b0, i_q_stat.count} + (Q_CNT_W + 1)'(r_sq_vld && r_sq_last))
                        < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        pos_inc = {1'b0, r_pos} + LEN_W'(1);
        last    = (pos_inc >= i_len);
        n_pos   = last ? '0 : pos_inc[POS_W-1:0];
        mag     = i_sample[SAMPLE_BITS-1] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
        sq      = SQ_W'(mag) * SQ_W'(mag);
        sum     = SUM_W'(r_acc) + SUM_W'(r_sq);
        acc_sat = (sum > SUM_W'(ENERGY_MAX)) ? ENERGY_MAX : sum[ENERGY_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq      <= sq;
            r_sq_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sq_vld <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_sq_vld <= accept;
            if (accept) begin
                r_pos <= n_pos;
            end
            if (r_sq_vld) begin
                r_acc <= r_sq_last ? '0 : acc_sat;
            end
        end
    end

    assign o_push      = r_sq_vld && r_sq_last;
    assign o_push_data = acc_sat;
endmodule

>>> rtl/evh_back.sv
// Back end: loudness decision, hangover state machine and result register.
`timescale 1ns / 1ps
module evh_back
    import evh_pkg::*;
#(
    parameter int LEN_W = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [THR_W-1:0]    i_thr,
    input  logic [LEN_W-1:0]    i_len,
    input  logic [HANG_W-1:0]   i_hang,
    input  t_q_stat             i_q_stat,
    input  logic [ENERGY_W-1:0] i_q_data,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_is_speech,
    output logic [ENERGY_W-1:0] o_frame_energy,
    output logic [1:0]          o_vad_mode
);
    localparam int PROD_W = THR_W + LEN_W;
    localparam int CMP_W  = (PROD_W > ENERGY_W) ? PROD_W : ENERGY_W;

    logic [PROD_W-1:0]   r_thr_len;
    t_mode               r_mode, n_mode;
    logic [CNT_W-1:0]    r_quiet, n_quiet;
    logic                r_out_vld;
    logic                r_speech;
    logic [ENERGY_W-1:0] r_energy;
    logic [1:0]          r_code;

    logic             load;
    logic             loud;
    logic [CNT_W-1:0] quiet_inc;

    // threshold times frame length, refreshed every cycle from the registers
    always_ff @(posedge i_clk) begin
        r_thr_len <= PROD_W'(i_thr) * PROD_W'(i_len);
    end

    assign load  = i_q_stat.not_empty && (!r_out_vld || i_out_ready);
    assign o_pop = load;

    always_comb begin
        loud      = CMP_W'(i_q_data) >= CMP_W'(r_thr_len);
        quiet_inc = (r_quiet == COUNT_MAX) ? r_quiet : r_quiet + CNT_W'(1);
        n_mode    = r_mode;
        n_quiet   = r_quiet;
        unique case (r_mode)
            ST_SPEECH: begin
                if (!loud) begin
                    n_mode  = ST_HANGOVER;
                    n_quiet = '0;
                end
            end
            ST_HANGOVER: begin
                if (loud) begin
                    n_mode = ST_SPEECH;
                end else begin
                    n_quiet = quiet_inc;
                    if (quiet_inc >= i_hang) begin
                        n_mode = ST_SILENCE;
                    end
                end
            end
            default: begin
                n_mode = loud ? ST_SPEECH : ST_SILENCE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_energy <= i_q_data;
            r_code   <= mode_code(n_mode);
            r_speech <= (n_mode != ST_SILENCE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ST_SILENCE;
            r_quiet   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_mode  <= n_mode;
                r_quiet <= n_quiet;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_is_speech    = r_speech;
    assign o_frame_energy = r_energy;
    assign o_vad_mode     = r_code;
endmodule

>>> rtl/energy_vad_hangover.sv
// Energy VAD with hangover: channel ports, configuration registers, front/queue/back.
//
// Usage:
//   Sample channel: i_sample with i_in_valid / o_in_ready, one sample per request.
//   Result channel: o_is_speech, o_frame_energy, o_vad_mode with o_out_valid /
//   i_out_ready, one result per finished frame.
//   Config channel: i_cfg_index / i_cfg_data with i_cfg_valid / o_cfg_ready,
//   always ready; index 0 frame length, 1 energy threshold, 2 hangover frames,
//   others ignored. Write only while the block is idle.
//   Throughput: one sample per cycle while o_in_ready is high, set by the
//   square and accumulate stages in the front end.
//   Result path: a frame's result becomes valid after its last sample is
//   accepted, passing the square stage, accumulate/queue and result register.
//   Receiver stall: finished frames wait in a four-entry queue; o_in_ready
//   drops only when that queue cannot take another frame end.
//   Reset: synchronous, active low; registers return to their defaults,
//   the frame sum and position clear and the mode returns to silence.
`timescale 1ns / 1ps
`include "energy_vad_hangover_macros.svh"
module energy_vad_hangover
    import evh_pkg::*;
#(
    parameter int MAX_FRAME_LENGTH = DEF_MAX_FRAME_LENGTH,
    parameter int SAMPLE_BITS      = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_is_speech,
    output logic [ENERGY_W-1:0]    o_frame_energy,
    output logic [1:0]             o_vad_mode,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int POS_W = $clog2(MAX_FRAME_LENGTH);
    localparam int LEN_W = POS_W + 1;
    localparam int CW    = (LEN_W > FL_W) ? LEN_W : FL_W;

    logic [FL_W-1:0]   r_frame_len;
    logic [THR_W-1:0]  r_thr;
    logic [HANG_W-1:0] r_hang;

    logic [LEN_W-1:0]    eff_len;
    t_q_stat             q_stat;
    logic                push, pop;
    logic [ENERGY_W-1:0] push_data, q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= RST_FRAME_LENGTH;
            r_thr       <= RST_THRESHOLD;
            r_hang      <= RST_HANGOVER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_LENGTH: r_frame_len <= i_cfg_data[FL_W-1:0];
                CFG_THRESHOLD:    r_thr       <= i_cfg_data[THR_W-1:0];
                CFG_HANGOVER:     r_hang      <= i_cfg_data[HANG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as one, lengths above the maximum are clamped
    always_comb begin
        priority if (r_frame_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (CW'(r_frame_len) > CW'(MAX_FRAME_LENGTH)) begin
            eff_len = LEN_W'(MAX_FRAME_LENGTH);
        end else begin
            eff_len = LEN_W'(r_frame_len);
        end
    end

    evh_front #(
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_len       (eff_len),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    evh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    evh_back #(
        .LEN_W (LEN_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_thr          (r_thr),
        .i_len          (eff_len),
        .i_hang         (r_hang),
        .i_q_stat       (q_stat),
        .i_q_data       (q_data),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_is_speech    (o_is_speech),
        .o_frame_energy (o_frame_energy),
        .o_vad_mode     (o_vad_mode)
    );

    `EVH_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH))
    `EVH_ASSERT_IMP(a_ready_has_room, i_clk, i_rst_n, o_in_ready, q_stat.count < Q_CNT_W'(Q_DEPTH))
    `EVH_ASSERT_IMP(a_speech_flag, i_clk, i_rst_n, o_out_valid, o_is_speech == (o_vad_mode != VAD_SILENCE))
    `EVH_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, q_stat.not_empty && (!o_out_valid || i_out_ready), o_out_valid)
endmodule

>>> sim/vad_frame_checker.sv
// Frame-level predictor and result checker for the energy VAD with hangover.
`timescale 1ns / 1ps
module vad_frame_checker
    import evh_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [DEF_SAMPLE_BITS-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_is_speech,
    input  logic [ENERGY_W-1:0]        i_frame_energy,
    input  logic [1:0]                 i_vad_mode,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_pending,
    output int                         o_fail_count
);

    typedef struct packed {
        logic                is_speech;
        logic [ENERGY_W-1:0] energy;
        logic [1:0]          vad_mode;
    } t_frame_verdict;

    t_frame_verdict      due_frames[$];

    logic [FL_W-1:0]     frame_len;
    logic [THR_W-1:0]    threshold;
    logic [HANG_W-1:0]   hangover;
    logic [ENERGY_W-1:0] energy_sum;
    logic [9:0]          sample_pos;
    logic [1:0]          vad_state;
    logic [CNT_W-1:0]    quiet_frames;

    int fail_count  = 0;
    int frames_seen = 0;

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        fail_count++;
        $display("frame %0d: %s got %0d expected %0d", frames_seen, what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        logic [11:0]           span;
        logic [15:0]           mag;
        logic [ENERGY_W-1:0]   square;
        logic [ENERGY_W:0]     total;
        logic [THR_W+11:0]     bar;
        logic                  loud;
        t_frame_verdict        want;

        if (!i_rst_n) begin
            frame_len    = RST_FRAME_LENGTH;
            threshold    = RST_THRESHOLD;
            hangover     = RST_HANGOVER;
            energy_sum   = '0;
            sample_pos   = '0;
            vad_state    = VAD_SILENCE;
            quiet_frames = '0;
            due_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FRAME_LENGTH: frame_len = i_cfg_data[FL_W-1:0];
                    CFG_THRESHOLD:    threshold = i_cfg_data[THR_W-1:0];
                    CFG_HANGOVER:     hangover  = i_cfg_data[HANG_W-1:0];
                    default: ;
                endcase
            end

            // results leave before this edge's sample can produce one
            if (i_out_valid && i_out_ready) begin
                if (due_frames.size() == 0) begin
                    flag_mismatch("unrequested result, energy", i_frame_energy, 0);
                end else begin
                    want = due_frames[0];
                    due_frames.delete(0);
                    if (i_is_speech !== want.is_speech)
                        flag_mismatch("is_speech", i_is_speech, want.is_speech);
                    if (i_frame_energy !== want.energy)
                        flag_mismatch("frame_energy", i_frame_energy, want.energy);
                    if (i_vad_mode !== want.vad_mode)
                        flag_mismatch("vad_mode", i_vad_mode, want.vad_mode);
                end
                frames_seen++;
            end

            if (i_in_valid && i_in_ready) begin
                if (frame_len == '0)
                    span = 12'd1;
                else if (frame_len > 11'd1024)
                    span = 12'd1024;
                else
                    span = {1'b0, frame_len};

                mag    = i_sample[15] ? (~i_sample + 16'd1) : i_sample;
                square = mag * mag;
                total  = {1'b0, energy_sum} + {1'b0, square};
                energy_sum = total[ENERGY_W] ? ENERGY_MAX : total[ENERGY_W-1:0];

                if ({2'b00, sample_pos} + 12'd1 < span) begin
                    sample_pos = sample_pos + 10'd1;
                end else begin
                    bar  = threshold * span;
                    loud = energy_sum >= bar;
                    case (vad_state)
                        VAD_SPEECH: begin
                            if (!loud) begin
                                vad_state    = VAD_HANGOVER;
                                quiet_frames = '0;
                            end
                        end
                        VAD_HANGOVER: begin
                            if (loud) begin
                                vad_state = VAD_SPEECH;
                            end else begin
                                if (quiet_frames != COUNT_MAX)
                                    quiet_frames = quiet_frames + 1'b1;
                                if (quiet_frames >= hangover)
                                    vad_state = VAD_SILENCE;
                            end
                        end
                        default: vad_state = loud ? VAD_SPEECH : VAD_SILENCE;
                    endcase
                    want.is_speech = (vad_state != VAD_SILENCE);
                    want.energy    = energy_sum;
                    want.vad_mode  = vad_state;
                    due_frames.insert(due_frames.size(), want);
                    energy_sum = '0;
                    sample_pos = '0;
                end
            end
        end
        o_pending    <= due_frames.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> sim/tb.sv
// Top-level testbench for the energy VAD with hangover: stimulus, clocking, verdict.
`timescale 1ns / 1ps
module tb;
    import evh_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS  = 550;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;
    localparam int LIMIT_CYCLES  = 400000;

    logic                       i_clk;
    logic                       rst_n;
    logic                       smp_valid;
    logic                       smp_ready;
    logic [DEF_SAMPLE_BITS-1:0] smp_data;
    logic                       res_valid;
    logic                       res_ready;
    logic                       is_speech;
    logic [ENERGY_W-1:0]        frame_energy;
    logic [1:0]                 vad_mode;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    int frames_due;
    int fail_count;
    int cycle_count   = 0;
    int src_max       = 17;
    int snk_max       = 17;
    int frame_samples = 400;
    bit hold_req      = 1'b0;

    energy_vad_hangover i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (smp_valid),
        .o_in_ready     (smp_ready),
        .i_sample       (smp_data),
        .o_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .o_is_speech    (is_speech),
        .o_frame_energy (frame_energy),
        .o_vad_mode     (vad_mode),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    vad_frame_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (smp_valid),
        .i_in_ready     (smp_ready),
        .i_sample       (smp_data),
        .i_out_valid    (res_valid),
        .i_out_ready    (res_ready),
        .i_is_speech    (is_speech),
        .i_frame_energy (frame_energy),
        .i_vad_mode     (vad_mode),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_pending      (frames_due),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("energy_vad_hangover regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sample(input bit loud);
        int          mag;
        logic [15:0] value;
        mag = loud ? $urandom_range(4000, 32768) : $urandom_range(0, 90);
        if (mag == 32768)
            return 16'h8000;
        value = mag[15:0];
        if ($urandom_range(0, 1) == 1)
            value = -value;
        return value;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic configure(input logic [30:0] fl_word, input logic [30:0] thr_word,
                             input logic [30:0] hang_word);
        logic [31:0] junk;
        logic [10:0] fl_bits;
        write_reg(CFG_FRAME_LENGTH, fl_word);
        write_reg(CFG_THRESHOLD, thr_word);
        write_reg(CFG_HANGOVER, hang_word);
        if ($urandom_range(0, 3) == 0) begin
            junk = $urandom;
            write_reg(CFG_SPARE, junk[30:0]);
        end
        cfg_valid <= 1'b0;
        @(posedge i_clk);
        fl_bits = fl_word[10:0];
        if (fl_bits == 11'd0)
            frame_samples = 1;
        else if (fl_bits > 11'd1024)
            frame_samples = 1024;
        else
            frame_samples = int'(fl_bits);
    endtask

    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = $urandom_range(0, src_max);
        if (gap > 0) begin
            smp_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_valid <= 1'b1;
        smp_data  <= value;
        @(posedge i_clk);
        while (!smp_ready) @(posedge i_clk);
    endtask

    // drain outstanding frames, then let the pipeline go quiet
    task automatic settle();
        smp_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : drain
        int gap;
        res_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            gap = $urandom_range(0, snk_max);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_valid && res_ready)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        logic [15:0] opening [9];
        logic [31:0] junk;
        logic [30:0] fl_word;
        logic [30:0] thr_word;
        logic [30:0] hang_word;
        int          rand_items;
        int          phase;
        int          fl;
        int          hang;
        int          thr;
        int          frames;
        int          seg;
        int          quiet_cap;
        bit          loud;

        opening = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0001,
                    16'hFFFF, 16'd1000, 16'd999, 16'hFC18};
        rst_n     <= 1'b0;
        smp_valid <= 1'b0;
        smp_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // one-sample frames, zero hangover, loud/quiet at the exact threshold
        configure(31'h7FFF_F801, 31'd1000000, 31'h7FFF_FC00);
        foreach (opening[k]) send_sample(opening[k]);
        settle();

        // zero frame length acts as one; zero threshold makes silence loud
        configure(31'd0, 31'd0, 31'h7FFF_FC02);
        send_sample(16'h0000);
        settle();

        // largest threshold: even full-scale is quiet, hangover runs out
        configure(31'd0, 31'h7FFF_FFFF, 31'd2);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h0000);
        settle();

        // frame length dropped below the current position
        configure(31'd200, 31'd1000000, 31'd5);
        repeat (4) send_sample(pick_sample(1'b1));
        settle();
        configure(31'd2, 31'd1000000, 31'd5);
        repeat (3) send_sample(pick_sample($urandom_range(0, 1) == 1));
        settle();

        // oversize frame length clamps to the maximum; full-scale meets the top threshold
        configure(31'h7FFF_FFFF, 31'h4000_0000, 31'd0);
        repeat (1024) send_sample(16'h8000);
        settle();

        rand_items = 0;
        phase      = 0;
        while (rand_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                7, 8:    fl = $urandom_range(9, 40);
                9:       fl = 0;
                default: fl = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    hang = $urandom_range(5, 20);
                9:       hang = $urandom_range(0, 1023);
                default: hang = $urandom_range(0, 4);
            endcase
            if (phase == 0)
                fl = 1;
            if (phase == 1)
                hang = 1023;
            if (phase == 2)
                hang = 0;

            junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
            fl_word = {junk[30:11], fl[10:0]};
            junk = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
            hang_word = {junk[30:10], hang[9:0]};
            case ($urandom_range(0, 7))
                0: thr_word = 31'd0;
                1: thr_word = 31'h7FFF_FFFF;
                2: begin
                    junk = $urandom;
                    thr_word = junk[30:0];
                end
                default: begin
                    thr = $urandom_range(10000, 10000000);
                    thr_word = thr[30:0];
                end
            endcase
            configure(fl_word, thr_word, hang_word);

            src_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            snk_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            frames  = $urandom_range(3, 3 + 200 / frame_samples);
            if (phase == 0) begin
                // back up the result queue until the sample side stalls
                src_max  = 0;
                frames   = 60;
                hold_req = 1'b1;
            end
            quiet_cap = (hang < 10) ? hang + 3 : 12;

            while (frames > 0) begin
                loud = ($urandom_range(0, 1) == 1);
                seg  = loud ? $urandom_range(1, 4) : $urandom_range(1, quiet_cap);
                while (seg > 0 && frames > 0) begin
                    repeat (frame_samples) begin
                        if ($urandom_range(0, 9) == 0) begin
                            junk = $urandom;
                            send_sample(junk[15:0]);
                        end else begin
                            send_sample(pick_sample(loud));
                        end
                        rand_items++;
                    end
                    seg--;
                    frames--;
                end
            end
            settle();
            phase++;
        end

        if (fail_count == 0)
            $display("energy_vad_hangover regression: pass");
        else
            $display("energy_vad_hangover regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/evh_pkg.sv
rtl/evh_queue.sv
rtl/evh_front.sv
rtl/evh_back.sv
rtl/energy_vad_hangover.sv
sim/vad_frame_checker.sv
sim/tb.sv
